@@ design/ectt_pkg.sv @@
// Shared types and constants for the eased color transition table.
package ectt_pkg;

  localparam logic [31:0] HASH_MUL     = 32'd2246822519;
  localparam logic [19:0] MAX_FRAME_US = 20'd100000;
  localparam logic [19:0] DUR_RESET    = 20'd120000;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_EASE1,
    ST_EASE2,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } state_t;

  localparam logic [0:0] REG_DURATION = 1'b0;

endpackage

@@ design/eased_color_transition_table.sv @@
// Top level: configuration register, request front end, queue and engine.
// A frame start runs through the bit-serial step divider. A color query with
// fades disabled goes straight to the hover and press mixes; otherwise it does
// one read and one write of the slot table per channel, two easing multiplies
// per channel that hits, and then the mixes. After reset the slot table is
// swept clear, one slot per cycle, before any request is started;
// configuration writes are taken throughout.
module eased_color_transition_table #(
  parameter int SLOT_COUNT          = 512,
  parameter int LEVEL_FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [19:0] frame_time_us,
  input  logic [31:0] element_id,
  input  logic [31:0] base_color,
  input  logic [31:0] hover_color,
  input  logic [31:0] press_color,
  input  logic        pointer_over,
  input  logic        is_pressed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] shown_color,
  output logic [LEVEL_FRACTION_BITS:0] hover_amount,
  output logic [LEVEL_FRACTION_BITS:0] press_amount
);
  import ectt_pkg::*;

  localparam int REQ_W = 1 + 20 + 32 * 4 + 2;

  logic [19:0]      duration;
  logic             q_valid;
  logic             q_take;
  logic [REQ_W-1:0] q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_DURATION, 1'b0}) ? {12'd0, duration} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= DUR_RESET;
    end else if (psel && penable && pwrite && paddr == {REG_DURATION, 1'b0}) begin
      duration <= pwdata[19:0];
    end
  end

  ectt_queue #(.WIDTH(REQ_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_stall (in_stall),
    .wr_data  ({action, frame_time_us, element_id, base_color, hover_color,
                press_color, pointer_over, is_pressed}),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_data)
  );

  ectt_engine #(
    .SLOT_COUNT          (SLOT_COUNT),
    .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS),
    .REQ_W               (REQ_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .duration  (duration),
    .req_valid (q_valid),
    .req_take  (q_take),
    .req_data  (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_color (shown_color),
    .out_hover (hover_amount),
    .out_press (press_amount)
  );
endmodule

@@ design/ectt_queue.sv @@
// Two-entry request queue between the front part and the back part.
module ectt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_take,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] entry [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |=> (count <= 2'd1))
    else $error("queue popped while empty");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2))
    else $error("queue lost an entry while full");
endmodule

@@ design/ectt_engine.sv @@
// Back part: frame step divider, slot table update, easing and color mix.
module ectt_engine #(
  parameter int SLOT_COUNT          = 512,
  parameter int LEVEL_FRACTION_BITS = 16,
  parameter int REQ_W               = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [19:0]        duration,
  input  logic               req_valid,
  output logic               req_take,
  input  logic [REQ_W-1:0]   req_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_color,
  output logic [LEVEL_FRACTION_BITS:0] out_hover,
  output logic [LEVEL_FRACTION_BITS:0] out_press
);
  import ectt_pkg::*;

  localparam int F    = LEVEL_FRACTION_BITS;
  localparam int LW   = F + 1;
  localparam int IW   = $clog2(SLOT_COUNT);
  localparam int NW   = 20 + F;   // dividend width
  localparam int QCW  = $clog2(NW + 1);
  localparam logic [LW-1:0] ONE = LW'(1) << F;

  // Request fields.
  logic        r_action;
  logic [19:0] r_time;
  logic [31:0] r_id;
  logic [31:0] r_base;
  logic [31:0] r_hov;
  logic [31:0] r_prs;
  logic        r_over;
  logic        r_press;
  assign {r_action, r_time, r_id, r_base, r_hov, r_prs, r_over, r_press} = req_data;

  state_t state;
  state_t state_next;

  // Table memory and valid flags cleared by a sweep after reset.
  logic [31:0]   mem_key   [SLOT_COUNT];
  logic [LW-1:0] mem_level [SLOT_COUNT];
  logic          mem_vld   [SLOT_COUNT];
  logic [31:0]   rd_key;
  logic [LW-1:0] rd_level;
  logic          rd_vld;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_key;
  logic [LW-1:0] wr_level;
  logic          wr_vld;
  logic [IW-1:0] clr_idx;

  logic          chan;        // 0 = hover, 1 = press
  logic [LW-1:0] frame_step;
  logic [LW-1:0] lvl_h;
  logic [LW-1:0] lvl_p;
  logic [LW-1:0] ease_in;
  logic [LW-1:0] t2;
  logic [31:0]   mix_a;
  logic [31:0]   color;

  // Divider registers.
  logic [NW-1:0]  div_num;
  logic [20:0]    div_rem;
  logic [NW-1:0]  div_q;
  logic [QCW-1:0] div_cnt;

  logic [31:0]   key;
  logic [IW-1:0] idx;
  logic          target;
  logic [LW-1:0] tgt_lvl;
  logic [LW-1:0] stepped;
  logic [20:0]   rem_sh;

  assign key     = r_id ^ (chan ? (HASH_MUL * 32'd2) : HASH_MUL);
  assign idx     = key[IW-1:0];
  assign target  = chan ? r_press : r_over;
  assign tgt_lvl = target ? ONE : '0;
  assign rem_sh  = {div_rem[19:0], div_num[NW-1]};

  always_comb begin
    stepped = rd_level;
    if (rd_level < tgt_lvl) begin
      stepped = ((tgt_lvl - rd_level) > frame_step) ? rd_level + frame_step : tgt_lvl;
    end else if (rd_level > tgt_lvl) begin
      stepped = ((rd_level - tgt_lvl) > frame_step) ? rd_level - frame_step : tgt_lvl;
    end
  end

  function automatic logic [7:0] mix_chan(input logic [7:0] a, input logic [7:0] b,
                                          input logic [LW-1:0] t);
    logic signed [F+11:0] v;
    logic signed [F+11:0] hi;
    logic [F+11:0]        r;
    begin
      v  = ($signed({{(F+4){1'b0}}, a}) <<< F) +
           ($signed({4'b0, b}) - $signed({4'b0, a})) * $signed({1'b0, t});
      hi = $signed({{(F+4){1'b0}}, 8'd255}) <<< F;
      if (v < 0) v = '0;
      if (v > hi) v = hi;
      r = (F+12)'(v) + ((F+12)'(1) << (F - 1));
      mix_chan = r[F+7:F];
    end
  endfunction

  function automatic logic [31:0] mix_rgba(input logic [31:0] a, input logic [31:0] b,
                                           input logic [LW-1:0] t);
    logic [31:0] res;
    begin
      res = '0;
      for (int k = 0; k < 4; k++) begin
        res[k*8 +: 8] = mix_chan(a[k*8 +: 8], b[k*8 +: 8], t);
      end
      if (t == '0) res = a;
      else if (t >= ONE) res = b;
      mix_rgba = res;
    end
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == IW'(SLOT_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          if (r_action == ACT_FRAME) state_next = ST_DIV;
          else if (duration == '0) state_next = ST_MIX1;
          else state_next = ST_RD;
        end
      end
      ST_DIV:   if (div_cnt == '0) state_next = ST_IDLE;
      ST_RD:    state_next = ST_UPD;
      ST_UPD: begin
        if (!rd_vld || rd_key != key) state_next = chan ? ST_MIX1 : ST_RD;
        else state_next = ST_EASE1;
      end
      ST_EASE1: state_next = ST_EASE2;
      ST_EASE2: state_next = chan ? ST_MIX1 : ST_RD;
      ST_MIX1:  state_next = ST_MIX2;
      ST_MIX2:  state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = idx;
    wr_key    = key;
    wr_level  = tgt_lvl;
    wr_vld    = 1'b1;
    req_take  = 1'b0;
    out_valid = (state == ST_OUT);
    unique case (state)
      ST_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = clr_idx;
        wr_key = '0;
        wr_level = '0;
        wr_vld = 1'b0;
      end
      ST_UPD: begin
        wr_en = 1'b1;
        if (rd_vld && rd_key == key) wr_level = stepped;
      end
      ST_DIV: req_take = (div_cnt == '0);
      ST_OUT: req_take = !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_idx]   <= wr_key;
      mem_level[wr_idx] <= wr_level;
      mem_vld[wr_idx]   <= wr_vld;
    end
    rd_key   <= mem_key[idx];
    rd_level <= mem_level[idx];
    rd_vld   <= mem_vld[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      frame_step <= '0;
      chan       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + IW'(1);
      if (state == ST_IDLE && req_valid) begin
        chan <= 1'b0;
        if (r_action == ACT_FRAME) begin
          div_num <= NW'(((r_time > MAX_FRAME_US) ? MAX_FRAME_US : r_time)) << F;
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= QCW'(NW);
        end else begin
          lvl_h <= r_over ? ONE : '0;
          lvl_p <= r_press ? ONE : '0;
        end
      end
      // Restoring division, one quotient bit per cycle.
      if (state == ST_DIV) begin
        if (div_cnt != '0) begin
          div_num <= div_num << 1;
          if (rem_sh >= {1'b0, duration}) begin
            div_rem <= rem_sh - {1'b0, duration};
            div_q   <= {div_q[NW-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh;
            div_q   <= {div_q[NW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - QCW'(1);
        end else if (duration == '0 || div_q > NW'(ONE)) begin
          frame_step <= ONE;
        end else begin
          frame_step <= div_q[LW-1:0];
        end
      end
      if (state == ST_UPD) begin
        if (!rd_vld || rd_key != key) begin
          chan <= 1'b1;
        end else begin
          ease_in <= stepped;
        end
      end
      if (state == ST_EASE1) begin
        t2 <= LW'((2*LW)'(ease_in) * (2*LW)'(ease_in) >> F);
      end
      if (state == ST_EASE2) begin
        if (chan) lvl_p <= LW'(((2*LW+2)'(t2) * ((2*LW+2)'(ONE) * 3 -
                                (2*LW+2)'(ease_in) * 2)) >> F);
        else lvl_h <= LW'(((2*LW+2)'(t2) * ((2*LW+2)'(ONE) * 3 -
                           (2*LW+2)'(ease_in) * 2)) >> F);
        chan <= 1'b1;
      end
      if (state == ST_MIX1) mix_a <= mix_rgba(r_base, r_hov, lvl_h);
      if (state == ST_MIX2) color <= mix_rgba(mix_a, r_prs, lvl_p);
    end
  end

  assign out_color = color;
  assign out_hover = lvl_h;
  assign out_press = lvl_p;

  a_out_only_query: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (r_action == ACT_QUERY))
    else $error("result shown for a frame start");
  a_step_bound: assert property (@(posedge clk) disable iff (rst) frame_step <= ONE)
    else $error("frame step above one");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_color)))
    else $error("stalled result changed");
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the eased color transition table.
module tb;
  import ectt_pkg::*;

  localparam int  SLOTS = 512;
  localparam int  FB    = 16;
  localparam longint ONE = 64'd1 << FB;

  typedef struct {
    action_t     act;
    logic [19:0] ft;
    logic [31:0] id;
    logic [31:0] base;
    logic [31:0] hov;
    logic [31:0] prs;
    logic        po;
    logic        ip;
    bit          typed;
    logic [31:0] col;
    logic [16:0] ha;
    logic [16:0] pa;
  } req_t;

  typedef struct {
    logic [31:0] col;
    logic [16:0] ha;
    logic [16:0] pa;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [19:0] frame_time_us = '0;
  logic [31:0] element_id = '0, base_color = '0, hover_color = '0, press_color = '0;
  logic        pointer_over = 1'b0, is_pressed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] shown_color;
  logic [16:0] hover_amount, press_amount;

  // Predictor state.
  logic [31:0] fade_key [SLOTS];
  longint      fade_level [SLOTS];
  bit          fade_used [SLOTS];
  longint      step_q16;
  logic [19:0] fade_us;

  shade_t      shade_q[$];
  int          errs = 0;
  bit          calm = 1'b0;
  logic [31:0] id_pool [8];

  eased_color_transition_table i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint ease(longint t);
    longint t2;
    if (t > ONE) t = ONE;
    t2 = (t * t) >> FB;
    return (t2 * (3 * ONE - 2 * t)) >> FB;
  endfunction

  function automatic logic [7:0] mix8(longint a, longint b, longint t);
    longint v;
    longint r;
    v = (a << FB) + (b - a) * t;
    if (v < 0) v = 0;
    if (v > (longint'(255) << FB)) v = longint'(255) << FB;
    r = (v + (ONE >> 1)) >> FB;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint t);
    logic [31:0] res;
    if (t == 0) return a;
    if (t >= ONE) return b;
    for (int sh = 0; sh < 32; sh += 8)
      res[sh +: 8] = mix8(a[sh +: 8], b[sh +: 8], t);
    return res;
  endfunction

  function automatic longint fade_for(logic [31:0] id, int chan, logic on);
    longint      target;
    logic [31:0] key;
    int          idx;
    longint      lv;
    target = on ? ONE : 0;
    if (fade_us == 0) return target;
    key = id ^ 32'((chan + 1) * HASH_MUL);
    idx = key % SLOTS;
    if (!fade_used[idx] || fade_key[idx] != key) begin
      fade_used[idx] = 1'b1;
      fade_key[idx] = key;
      fade_level[idx] = target;
      return target;
    end
    lv = fade_level[idx];
    if (lv < target) lv = (target - lv > step_q16) ? lv + step_q16 : target;
    else if (lv > target) lv = (lv - target > step_q16) ? lv - step_q16 : target;
    fade_level[idx] = lv;
    return ease(lv);
  endfunction

  function automatic void predict_shade(req_t r);
    longint dt;
    longint h;
    longint p;
    shade_t s;
    if (r.act == ACT_FRAME) begin
      dt = r.ft;
      if (dt > MAX_FRAME_US) dt = MAX_FRAME_US;
      if (fade_us == 0) step_q16 = ONE;
      else begin
        step_q16 = (dt << FB) / fade_us;
        if (step_q16 > ONE) step_q16 = ONE;
      end
      return;
    end
    h = fade_for(r.id, 0, r.po);
    p = fade_for(r.id, 1, r.ip);
    s.col = blend(blend(r.base, r.hov, h), r.prs, p);
    s.ha = h[16:0];
    s.pa = p[16:0];
    if (r.typed) begin
      s.col = r.col;
      s.ha = r.ha;
      s.pa = r.pa;
    end
    shade_q.push_back(s);
  endfunction

  function automatic bit idle_now();
    return !calm && $urandom_range(99) < 16;
  endfunction

  // Valid stays high after a request is taken; the next send or drain decides.
  task automatic send(req_t r);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.act;
    frame_time_us <= r.ft;
    element_id <= r.id;
    base_color <= r.base;
    hover_color <= r.hov;
    press_color <= r.prs;
    pointer_over <= r.po;
    is_pressed <= r.ip;
    do @(posedge clk); while (in_stall);
    predict_shade(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    // Up to two trailing frame starts produce no result but keep the divider busy.
    repeat (128) @(posedge clk);
  endtask

  task automatic set_duration(logic [19:0] us);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(4 * REG_DURATION);
    pwdata <= {12'd0, us};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fade_us = us;
  endtask

  function automatic req_t random_req();
    req_t r;
    r.typed = 1'b0;
    r.act = ($urandom_range(99) < 20) ? ACT_FRAME : ACT_QUERY;
    r.ft = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(30000));
    r.id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(7)] : $urandom;
    r.base = $urandom;
    r.hov = $urandom;
    r.prs = $urandom;
    r.po = 1'($urandom_range(1));
    r.ip = 1'($urandom_range(1));
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= !calm && $urandom_range(99) < 16;
    if (out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $error("result with no request pending");
        errs++;
      end else begin
        shade_t s;
        s = shade_q.pop_front();
        if (shown_color !== s.col) begin
          $error("shown_color expected %h actual %h", s.col, shown_color);
          errs++;
        end
        if (hover_amount !== s.ha) begin
          $error("hover_amount expected %h actual %h", s.ha, hover_amount);
          errs++;
        end
        if (press_amount !== s.pa) begin
          $error("press_amount expected %h actual %h", s.pa, press_amount);
          errs++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[eased_color_transition_table] ERROR");
    $finish;
  end

  initial begin
    req_t        steps[$];
    req_t        r;
    logic [19:0] durations[6];
    durations = '{20'd1000000, 20'd0, 20'd1, 20'hFFFFF, 20'd5000, 20'd120000};
    for (int i = 0; i < SLOTS; i++) begin
      fade_key[i] = '0;
      fade_level[i] = 0;
      fade_used[i] = 1'b0;
    end
    step_q16 = 0;
    fade_us = DUR_RESET;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFFFFFF;

    // Directed requests; typed rows are fresh slots whose level jumps to target.
    steps = '{
      '{ACT_QUERY, 20'd0, 32'h0, 32'h11223344, 32'hAABBCCDD, 32'hFFFFFFFF,
        1'b0, 1'b0, 1'b1, 32'h11223344, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'hFFFFFFFF, 32'h00000000, 32'h80808080, 32'h01020304,
        1'b1, 1'b1, 1'b1, 32'h01020304, 17'h10000, 17'h10000},
      '{ACT_QUERY, 20'd0, 32'h12345678, 32'h00FF00FF, 32'hFF00FF00, 32'h0,
        1'b1, 1'b0, 1'b1, 32'hFF00FF00, 17'h10000, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h0,
        1'b1, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_FRAME, 20'd100000, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h0, 32'h00000000, 32'hFFFFFFFF, 32'h7F7F7F7F,
        1'b1, 1'b1, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h0, 32'hFF000000, 32'h00FF0000, 32'h0000FF00,
        1'b1, 1'b1, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h0, 32'h10203040, 32'hF0E0D0C0, 32'h55AA55AA,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_FRAME, 20'hFFFFF, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h80808080,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_FRAME, 20'd0, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h12345678, 32'h0, 32'hFFFFFFFF, 32'h0,
        1'b0, 1'b1, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_FRAME, 20'd3000, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0},
      '{ACT_QUERY, 20'd0, 32'h12345678, 32'h01010101, 32'hFEFEFEFE, 32'h0,
        1'b0, 1'b0, 1'b0, 32'h0, 17'd0, 17'd0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_duration(DUR_RESET);
    foreach (steps[i]) send(steps[i]);
    drain();

    foreach (durations[ph]) begin
      set_duration(durations[ph]);
      calm = (ph == 2);
      for (int n = 0; n < 180; n++) begin
        // Let the block empty out completely once in the middle of the first run.
        if (ph == 0 && n == 90) drain();
        r = random_req();
        send(r);
      end
      drain();
    end
    calm = 1'b0;

    if (errs == 0 && shade_q.size() == 0)
      $display("[eased_color_transition_table] OK");
    else
      $display("[eased_color_transition_table] ERROR");
    $finish;
  end

endmodule
